/* design/klifo_pkg.sv */
// Package for the keyed LIFO with remove-by-key.
// Holds request/response payload types, status codes and controller/datapath
// interface structs. No dependencies.
package klifo_pkg;

   localparam int KEY_W = 64;

   // Response status codes
   localparam logic [2:0] ST_PUSHED    = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_REMOVED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_EMPTY     = 3'd4;

   // Request operation codes
   localparam logic OP_PUSH   = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef struct packed {
      logic             operation;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [3:0] moves;
      logic [4:0] occupancy;
   } rsp_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       load;        // latch request, clear moves
      logic       push_wr;     // write key on top, bump count
      logic       scan_init;   // point scan at top entry
      logic       scan_rd;     // read at pointer, step pointer down
      logic       hit_latch;   // capture moves for the matched entry
      logic       shift_init;  // point reader just above the hole
      logic       shift_rd;    // read at pointer, step pointer up
      logic       shift_wr;    // write read data into hole, step hole up
      logic       dec;         // drop one from the count
      logic       respond;     // register the response
      logic [2:0] code;        // status for the response
   } klifo_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic op;
      logic full;
      logic empty;
      logic hit;
      logic tag_zero;
      logic tag_top;
      logic shift_last;
   } klifo_sts_type;

endpackage

/* design/keyed_lifo_remove_by_key_unit.sv */
// Keyed LIFO with remove-by-key: top level joining controller and datapath.
// A request is taken when start is high and busy is low. A push passes
// through the decode and response states before its response strobe shows.
// A remove scans from the top, one entry per cycle through the store's
// single registered read port, then closes the gap by copying each entry
// above the match down one place, one entry per cycle. A remove takes longer
// the more entries it examines and, when entries lie above the match, the
// more entries it copies down. busy falls in the cycle the strobe shows, so
// the next request may be taken at the edge that ends it. The response sits
// on rsp_item for exactly one cycle while rsp_valid is high; the receiver
// cannot stall it. Store contents need no clearing after reset: only entries
// below the fill count are ever read.
// Depends on klifo_pkg, klifo_ctrl and klifo_dp.
module keyed_lifo_remove_by_key_unit
   import klifo_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   klifo_cmd_type cmd;
   klifo_sts_type sts;

   // Sequence each request
   klifo_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // Hold the keys, count and response
   klifo_dp #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

/* design/klifo_ctrl.sv */
// Controller state machine for the keyed LIFO.
// Sequences push, search and compaction; depends on klifo_pkg.
module klifo_ctrl
   import klifo_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  klifo_sts_type sts,
   output klifo_cmd_type cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_SCAN_RD  = 3'd2;
   localparam logic [2:0] S_SCAN_CMP = 3'd3;
   localparam logic [2:0] S_SHIFT_RD = 3'd4;
   localparam logic [2:0] S_SHIFT_WR = 3'd5;
   localparam logic [2:0] S_RESP     = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] code_ff, code_in;

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd      = '0;
      cmd.code = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.op == OP_PUSH) begin
               if (sts.full) begin
                  code_in = ST_FULL;
               end else begin
                  cmd.push_wr = 1'b1;
                  code_in     = ST_PUSHED;
               end
               state_in = S_RESP;
            end else if (sts.empty) begin
               code_in  = ST_EMPTY;
               state_in = S_RESP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCAN_CMP;
         end
         S_SCAN_CMP: begin
            if (sts.hit) begin
               cmd.hit_latch = 1'b1;
               code_in       = ST_REMOVED;
               if (sts.tag_top) begin
                  cmd.dec  = 1'b1;
                  state_in = S_RESP;
               end else begin
                  cmd.shift_init = 1'b1;
                  state_in       = S_SHIFT_RD;
               end
            end else if (sts.tag_zero) begin
               code_in  = ST_NOT_FOUND;
               state_in = S_RESP;
            end else begin
               cmd.scan_rd = 1'b1;
            end
         end
         S_SHIFT_RD: begin
            cmd.shift_rd = 1'b1;
            state_in     = S_SHIFT_WR;
         end
         S_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            if (sts.shift_last) begin
               cmd.dec  = 1'b1;
               state_in = S_RESP;
            end else begin
               cmd.shift_rd = 1'b1;
            end
         end
         S_RESP: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_PUSHED;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

/* design/klifo_dp.sv */
// Datapath for the keyed LIFO: key store, fill count, scan/shift pointers
// and the response register. Depends on klifo_pkg.
module klifo_dp
   import klifo_pkg::*;
#(
   parameter int DEPTH    = 16,
   parameter int KEY_BITS = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_item,
   input  klifo_cmd_type cmd,
   output klifo_sts_type sts,
   output logic          rsp_valid,
   output rsp_type       rsp_item
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [KEY_BITS-1:0] mem [DEPTH];

   logic                op_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic [KEY_BITS-1:0] rdata_ff;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [IW-1:0]       ptr_ff, ptr_in;
   logic [IW-1:0]       tag_ff, tag_in;
   logic [3:0]          moves_ff, moves_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [CW-1:0]       tag_c;
   logic [CW-1:0]       mv_diff;
   logic [CW+3:0]       mv_wide;
   logic [CW+4:0]       cnt_wide;
   logic [CW:0]         tag_p2;
   logic [4:0]          occ;
   logic                rd_en;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   logic [KEY_BITS-1:0] wr_data;

   assign tag_c    = CW'(tag_ff);
   assign mv_diff  = cnt_ff - CW'(1) - tag_c;
   assign mv_wide  = {4'b0, mv_diff};
   assign cnt_wide = {5'b0, cnt_ff};
   assign tag_p2   = {1'b0, tag_c} + (CW + 1)'(2);
   assign occ      = (cnt_wide > (CW + 5)'(31)) ? 5'd31 : cnt_wide[4:0];

   always_comb begin
      sts.op         = op_ff;
      sts.full       = (cnt_ff == CW'(DEPTH));
      sts.empty      = (cnt_ff == '0);
      sts.hit        = (rdata_ff == key_ff);
      sts.tag_zero   = (tag_ff == '0);
      sts.tag_top    = (tag_c == cnt_ff - CW'(1));
      sts.shift_last = (tag_p2 == {1'b0, cnt_ff});
   end

   // Pointer, hole and count updates
   always_comb begin
      cnt_in   = cnt_ff;
      ptr_in   = ptr_ff;
      tag_in   = tag_ff;
      moves_in = moves_ff;
      if (cmd.load) begin
         moves_in = '0;
      end
      if (cmd.push_wr) begin
         cnt_in = cnt_ff + CW'(1);
      end
      if (cmd.dec) begin
         cnt_in = cnt_ff - CW'(1);
      end
      if (cmd.scan_init) begin
         ptr_in = IW'(cnt_ff - CW'(1));
      end
      if (cmd.scan_rd) begin
         tag_in = ptr_ff;
         ptr_in = ptr_ff - IW'(1);
      end
      if (cmd.hit_latch) begin
         moves_in = (mv_wide > (CW + 4)'(15)) ? 4'd15 : mv_wide[3:0];
      end
      if (cmd.shift_init) begin
         ptr_in = tag_ff + IW'(1);
      end
      if (cmd.shift_rd) begin
         ptr_in = ptr_ff + IW'(1);
      end
      if (cmd.shift_wr) begin
         tag_in = tag_ff + IW'(1);
      end
   end

   assign rd_en   = cmd.scan_rd | cmd.shift_rd;
   assign wr_en   = cmd.push_wr | cmd.shift_wr;
   assign wr_addr = cmd.push_wr ? cnt_ff[IW-1:0] : tag_ff;
   assign wr_data = cmd.push_wr ? key_ff : rdata_ff;

   // Key store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= req_item.operation;
         key_ff <= req_item.key[KEY_BITS-1:0];
      end
      ptr_ff   <= ptr_in;
      tag_ff   <= tag_in;
      moves_ff <= moves_in;
      if (cmd.respond) begin
         rsp_ff.status    <= cmd.code;
         rsp_ff.moves     <= moves_ff;
         rsp_ff.occupancy <= occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

/* design/klifo_chk.sv */
// Port-level checks for the keyed LIFO, bound to the top level.
// Depends on klifo_pkg and keyed_lifo_remove_by_key_unit.
module klifo_chk
   import klifo_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   // Accepted request must raise busy next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request accepted");

   // Responses never come back to back
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe held for two cycles");

   // Busy drops as the response shows
   a_idle_on_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("busy high while response shown");

   // Occupancy never exceeds the store
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_item.occupancy) <= DEPTH))
      else $error("occupancy beyond store depth");

   // Moves only reported on a removal
   a_moves_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_item.status != ST_REMOVED)) |-> (rsp_item.moves == 4'd0))
      else $error("moves non-zero without removal");

endmodule

bind keyed_lifo_remove_by_key_unit klifo_chk #(.DEPTH(DEPTH)) u_klifo_chk (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
